// ===== hw/rtl/edf_pkg.sv =====
package edf_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_REJECTED = 3'd1,
        KIND_IDLE     = 3'd2,
        KIND_RUNNING  = 3'd3,
        KIND_COMPLETED = 3'd4,
        KIND_MISSED   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RUN,
        ST_WALK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] deadline;
        logic [15:0] remaining;
        logic [15:0] waiting;
        logic [15:0] turnaround;
        logic [15:0] response;
        logic        started;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  task_ref;
        logic [15:0] wait_time;
        logic [15:0] turn_time;
        logic [15:0] resp_time;
        logic [15:0] left_burst;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] burst_len;
        logic [15:0] abs_deadline;
        logic [7:0]  task_id;
        logic        mode;
    } word_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v != CNT_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

// ===== hw/rtl/edf_if.sv =====
interface edf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/edf_ctrl.sv =====
module edf_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic in_mode,
    output logic out_valid,
    input  logic out_ready,
    output edf_pkg::state_t state,
    input  logic step_done
);
    import edf_pkg::*;

    state_t state_reg, state_next;
    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // RUN: step_done means the first word is ready to go out now
    // (idle, or running followed by completed); otherwise walk first
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = in_mode ? ST_RUN : ST_SEARCH;
            ST_SEARCH:
                if (step_done) state_next = ST_SHIFT;
            ST_SHIFT:
                if (step_done) state_next = ST_OUT;
            ST_RUN:
                state_next = step_done ? ST_OUT : ST_WALK;
            ST_WALK:
                if (step_done) state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = step_done ? ST_IDLE : ST_WALK;
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/edf_datapath.sv =====
module edf_datapath #(
    parameter int QUEUE_DEPTH = edf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  edf_pkg::state_t state,
    input  logic in_fire,
    input  edf_pkg::word_t in_word,
    input  logic out_fire,
    output edf_pkg::result_t result,
    output logic step_done
);
    import edf_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] FRONT = '0;

    function automatic entry_t upd_front(input entry_t e);
        entry_t r;
        r = e;
        r.started = 1'b1;
        if (e.remaining != 16'd0) r.remaining = e.remaining - 16'd1;
        r.turnaround = sat_inc(e.turnaround);
        return r;
    endfunction

    entry_t      mem [QUEUE_DEPTH];
    logic [15:0] time_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_reg;   // read pointer of compaction walk
    logic [CW-1:0] wr_reg;   // write pointer
    logic        mode_reg;
    logic        running_reg;
    logic        done_reg;   // front completed, completed word follows running
    logic        miss_reg;   // miss found, pending word goes out first
    word_t       word_reg;
    result_t     res_reg;   // pending word; last set once nothing follows

    entry_t cur, upd, newe, fr;
    logic   keep;
    logic   rd_end;

    assign result = res_reg;
    assign cur = mem[rd_reg[IW-1:0]];
    assign fr = upd_front(mem[FRONT]);

    always_comb
    begin
        newe = '0;
        newe.id = word_reg.task_id;
        newe.deadline = word_reg.abs_deadline;
        newe.remaining = word_reg.burst_len;
        upd = cur;
        if (!(running_reg && rd_reg == '0))
        begin
            upd.waiting = sat_inc(cur.waiting);
            upd.turnaround = sat_inc(cur.turnaround);
            if (!cur.started)
                upd.response = sat_inc(cur.response);
        end
        keep = (upd.deadline != time_reg);
        rd_end = (rd_reg >= cnt_reg);
    end

    // step_done: search/shift/walk finished, in RUN: first word ready without a walk, or in OUT: no more results
    always_comb
    begin
        case (state)
            ST_SEARCH: step_done = (mode_reg) || rd_end || (cur.deadline > word_reg.abs_deadline)
                                   || (cnt_reg == CW'(QUEUE_DEPTH));
            ST_SHIFT:  step_done = (wr_reg == rd_reg);
            ST_RUN:    step_done = (cnt_reg == '0) || (fr.remaining == 16'd0);
            ST_WALK:   step_done = rd_end || !keep;
            ST_OUT:    step_done = res_reg.last;
            default:   step_done = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state)
            ST_SHIFT:
                if (wr_reg != rd_reg)
                    mem[wr_reg[IW-1:0]] <= mem[wr_reg[IW-1:0] - IW'(1)];
                else if (cnt_reg != CW'(QUEUE_DEPTH))
                    mem[rd_reg[IW-1:0]] <= newe;
            ST_RUN:
                if (cnt_reg != '0)
                    mem[FRONT] <= fr;
            ST_WALK:
                if (!rd_end && keep)
                    mem[wr_reg[IW-1:0]] <= upd;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            cnt_reg  <= '0;
            rd_reg   <= '0;
            wr_reg   <= '0;
            done_reg <= 1'b0;
            miss_reg <= 1'b0;
            running_reg <= 1'b0;
            mode_reg <= 1'b0;
            word_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            case (state)
                ST_IDLE:
                    if (in_fire)
                    begin
                        word_reg <= in_word;
                        mode_reg <= in_word.mode;
                        rd_reg <= '0;
                        if (in_word.mode) time_reg <= time_reg + 16'd1;
                    end
                ST_SEARCH:
                    if (cnt_reg == CW'(QUEUE_DEPTH))
                    begin
                        res_reg <= '{KIND_REJECTED, word_reg.task_id, 16'd0, 16'd0,
                                     16'd0, 16'd0, 1'b1};
                        wr_reg <= rd_reg;
                    end
                    else if (step_done)
                        wr_reg <= cnt_reg;
                    else
                        rd_reg <= rd_reg + CW'(1);
                ST_SHIFT:
                    if (wr_reg != rd_reg)
                        wr_reg <= wr_reg - CW'(1);
                    else if (cnt_reg != CW'(QUEUE_DEPTH))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        res_reg <= '{KIND_ACCEPTED, word_reg.task_id, 16'd0, 16'd0,
                                     16'd0, word_reg.burst_len, 1'b1};
                    end
                ST_RUN:
                begin
                    rd_reg <= '0;
                    wr_reg <= '0;
                    done_reg <= 1'b0;
                    miss_reg <= 1'b0;
                    if (cnt_reg == '0)
                        res_reg <= '{KIND_IDLE, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
                    else
                    begin
                        running_reg <= (fr.remaining != 16'd0);
                        res_reg <= '{KIND_RUNNING, fr.id, fr.waiting, fr.turnaround,
                                     fr.response, fr.remaining, 1'b0};
                        done_reg <= (fr.remaining == 16'd0);
                    end
                end
                ST_WALK:
                    if (rd_end)
                    begin
                        cnt_reg <= wr_reg;
                        res_reg.last <= 1'b1;
                    end
                    else if (keep)
                    begin
                        rd_reg <= rd_reg + CW'(1);
                        wr_reg <= wr_reg + CW'(1);
                    end
                    else
                        miss_reg <= 1'b1;
                ST_OUT:
                    if (out_fire && !res_reg.last)
                    begin
                        if (done_reg)
                        begin
                            // completed front: emit it, then skip it in the walk
                            done_reg <= 1'b0;
                            running_reg <= 1'b0;
                            res_reg <= '{KIND_COMPLETED, res_reg.task_ref, res_reg.wait_time,
                                         res_reg.turn_time, res_reg.resp_time, 16'd0, 1'b0};
                            rd_reg <= CW'(1);
                            wr_reg <= '0;
                        end
                        else if (miss_reg)
                        begin
                            // entry at rd is unchanged since the walk stopped on it
                            miss_reg <= 1'b0;
                            rd_reg <= rd_reg + CW'(1);
                            res_reg <= '{KIND_MISSED, upd.id, upd.waiting, upd.turnaround,
                                         upd.response, upd.remaining, 1'b0};
                        end
                    end
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/edf_ready_queue_scheduler.sv =====
// EDF ready queue scheduler.
// Input channel "in" carries one word per request: mode 0 inserts a task
// sorted by abs_deadline (ties behind), mode 1 advances time by one tick.
// Output channel "out" carries result words; last marks the final one.
// An arrival gives one word (accepted or rejected full), after a search for
// its position and a shift of the entries behind it.
// A tick gives idle, or running, maybe completed, then any deadline misses
// in queue order; it walks every entry once. One request is in flight at a
// time; ready is low until its last result word is taken.
// When the receiver stalls, the block holds the current result and waits.
// Reset clears the time counter and the entry count; entry storage is not
// cleared and needs no sweep.
module edf_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = edf_pkg::DEFAULT_QUEUE_DEPTH
) (
    input logic clk,
    input logic rst_n,
    edf_if.sink   in,
    edf_if.source out
);
    import edf_pkg::*;

    state_t  state;
    logic    step_done;
    result_t res;
    word_t   w;

    assign w = in.data;
    assign out.data = res;

    edf_ctrl u_ctrl (
        .clk, .rst_n,
        .in_valid (in.valid),
        .in_ready (in.ready),
        .in_mode  (w.mode),
        .out_valid(out.valid),
        .out_ready(out.ready),
        .state,
        .step_done
    );

    edf_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk, .rst_n,
        .state,
        .in_fire (in.valid && in.ready),
        .in_word (w),
        .out_fire(out.valid && out.ready),
        .result  (res),
        .step_done
    );

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in.ready && out.valid)) else $error("ready while result pending");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid) else $error("result dropped");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid |-> res.kind <= KIND_MISSED) else $error("bad kind");

endmodule

// ===== sim/tb_edf_ready_queue_scheduler.sv =====
module tb_edf_ready_queue_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import edf_pkg::*;

    localparam int QDEPTH = 16;

    // one pending input word plus its pacing flags
    typedef struct {
        word_t w;
        bit    drain;   // hold until every expected result has come
        bit    calm;    // final stretch: no idling on either side
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    edf_if #(.T(word_t))   in_ch ();
    edf_if #(.T(result_t)) out_ch ();

    edf_ready_queue_scheduler #(.QUEUE_DEPTH(QDEPTH)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // EDF queue shadow: sorted entries, time counter, live entry count
    // ---------------------------------------------------------------
    entry_t      sched_q [QDEPTH];
    int          sched_len = 0;
    logic [15:0] sched_now = 16'd0;

    result_t     results_due [$];   // expected result words, oldest first
    stim_t       pending [$];       // words not yet accepted by the block

    int          mismatches = 0;
    int          words_seen = 0;
    bit          calm_now = 1'b0;
    logic [15:0] gen_time = 16'd0;  // tick count seen by the generator

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] id,
                                            input logic [15:0] wt, input logic [15:0] tt,
                                            input logic [15:0] rt, input logic [15:0] left);
        result_t r;
        r.kind       = k;
        r.task_ref   = id;
        r.wait_time  = wt;
        r.turn_time  = tt;
        r.resp_time  = rt;
        r.left_burst = left;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic result_t from_entry(input kind_t k, input entry_t e);
        return make_result(k, e.id, e.waiting, e.turnaround, e.response, e.remaining);
    endfunction

    // Applies one accepted word to the shadow queue and queues its results.
    function automatic void sched_step(input word_t w);
        result_t batch [$];
        entry_t  e;
        int      pos;
        int      keep;
        int      cnt;
        bit      running;
        if (w.mode == 1'b0) begin
            if (sched_len >= QDEPTH)
                batch.push_back(make_result(KIND_REJECTED, w.task_id, '0, '0, '0, '0));
            else
            begin
                // ties go behind existing entries
                pos = 0;
                while (pos < sched_len && sched_q[pos].deadline <= w.abs_deadline)
                    pos++;
                for (int i = sched_len; i > pos; i--)
                    sched_q[i] = sched_q[i-1];
                e.id         = w.task_id;
                e.deadline   = w.abs_deadline;
                e.remaining  = w.burst_len;
                e.waiting    = '0;
                e.turnaround = '0;
                e.response   = '0;
                e.started    = 1'b0;
                sched_q[pos] = e;
                sched_len++;
                batch.push_back(make_result(KIND_ACCEPTED, w.task_id, '0, '0, '0,
                                            w.burst_len));
            end
        end
        else
        begin
            sched_now = sched_now + 16'd1;   // wraps
            if (sched_len == 0)
                batch.push_back(make_result(KIND_IDLE, 8'd0, '0, '0, '0, '0));
            else
            begin
                sched_q[0].started = 1'b1;
                if (sched_q[0].remaining != 16'd0)
                    sched_q[0].remaining = sched_q[0].remaining - 16'd1;
                sched_q[0].turnaround = bump(sched_q[0].turnaround);
                batch.push_back(from_entry(KIND_RUNNING, sched_q[0]));
                running = 1'b1;
                if (sched_q[0].remaining == 16'd0)
                begin
                    batch.push_back(from_entry(KIND_COMPLETED, sched_q[0]));
                    for (int i = 1; i < sched_len; i++)
                        sched_q[i-1] = sched_q[i];
                    sched_len--;
                    running = 1'b0;
                end
                // counter walk, then expiry in queue order (running task too)
                cnt = sched_len;
                keep = 0;
                for (int i = 0; i < cnt; i++)
                begin
                    if (!(running && i == 0))
                    begin
                        sched_q[i].waiting    = bump(sched_q[i].waiting);
                        sched_q[i].turnaround = bump(sched_q[i].turnaround);
                        if (!sched_q[i].started)
                            sched_q[i].response = bump(sched_q[i].response);
                    end
                    if (sched_q[i].deadline == sched_now)
                        batch.push_back(from_entry(KIND_MISSED, sched_q[i]));
                    else
                    begin
                        if (keep != i)
                            sched_q[keep] = sched_q[i];
                        keep++;
                    end
                end
                sched_len = keep;
            end
        end
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[i])
            results_due.push_back(batch[i]);
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers pending words, random gap bursts after acceptance
    // ---------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_in
        stim_t took;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (in_ch.valid)
            begin
                // word accepted at this edge
                took = pending.pop_front();
                sched_step(took.w);
                if (!took.calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (pending.size() > 0 && !(pending[0].drain && results_due.size() > 0))
            begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending[0].w;
                calm_now = pending[0].calm;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random ready stalls, one long hold-off, result checking
    // ---------------------------------------------------------------
    int hold_left = 0;
    bit held_long = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : watch_out
        result_t got;
        result_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                words_seen++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: kind %0d id %0d", got.kind,
                                 got.task_ref);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.task_ref !== want.task_ref ||
                        got.wait_time !== want.wait_time ||
                        got.turn_time !== want.turn_time ||
                        got.resp_time !== want.resp_time ||
                        got.left_burst !== want.left_burst || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch exp k%0d id%0d w%0d t%0d r%0d l%0d e%0d",
                                     want.kind, want.task_ref, want.wait_time,
                                     want.turn_time, want.resp_time, want.left_burst,
                                     want.last);
                            $display("                got k%0d id%0d w%0d t%0d r%0d l%0d e%0d",
                                     got.kind, got.task_ref, got.wait_time, got.turn_time,
                                     got.resp_time, got.left_burst, got.last);
                        end
                    end
                end
            end
            // long hold-off once, with the sender still offering
            if (!held_long && words_seen == 60)
            begin
                held_long = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm_now && $urandom_range(0, 5) == 0)
                    hold_left = $urandom_range(1, 17);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic add_word(input logic mode, input logic [7:0] id,
                            input logic [15:0] burst, input logic [15:0] dl,
                            input bit drain = 1'b0, input bit calm = 1'b0);
        stim_t s;
        s.w.mode         = mode;
        s.w.task_id      = id;
        s.w.burst_len    = burst;
        s.w.abs_deadline = dl;
        s.drain          = drain;
        s.calm           = calm;
        pending.push_back(s);
        if (mode)
            gen_time = gen_time + 16'd1;
    endtask

    task automatic add_tick(input bit drain = 1'b0, input bit calm = 1'b0);
        add_word(1'b1, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), drain, calm);
    endtask

    initial
    begin : stimulus
        int n_items;
        int k;
        logic [15:0] dl;

        // directed: idle tick, field extremes, ties, zero burst, miss
        add_tick();
        add_word(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF);
        add_word(1'b0, 8'h00, 16'd1, 16'd3);
        add_word(1'b0, 8'h05, 16'd0, 16'd3);     // tie, zero burst
        add_word(1'b0, 8'h07, 16'd2, 16'd2);
        add_word(1'b0, 8'h5A, 16'd9, 16'd0);     // deadline 0 lands in front
        repeat (4) add_tick();
        // fill the queue until arrivals get rejected
        for (int i = 0; i < 16; i++)
            add_word(1'b0, 8'(8'h10 + i), 16'($urandom_range(1, 4)), 16'(gen_time + 12 + i));
        add_tick();

        // random: noise words, or short arrival bursts with deadlines near now, then ticks
        n_items = 0;
        while (n_items < 400)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
            begin
                // noise: any value of any field
                add_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                n_items++;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    dl = gen_time + 16'($urandom_range(1, 40));
                    if ($urandom_range(0, 19) == 0)
                        add_word(1'b0, 8'($urandom_range(0, 255)), 16'd0, dl);
                    else
                        add_word(1'b0, 8'($urandom_range(0, 255)),
                                 16'($urandom_range(1, 20)), dl);
                    n_items++;
                end
                repeat ($urandom_range(1, 10))
                begin
                    add_tick(n_items > 200 && n_items < 215);
                    n_items++;
                end
            end
        end

        // final stretch, no idling: a drained arrival, then an arrival and ticks
        add_word(1'b0, 8'hA1, 16'hFFFF, gen_time, 1'b1, 1'b1);
        add_word(1'b0, 8'hA2, 16'd3, 16'(gen_time + 2), 1'b0, 1'b1);
        repeat (20) add_tick(1'b0, 1'b1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() > 0 || results_due.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== edf_ready_queue_scheduler.f =====
hw/rtl/edf_pkg.sv
hw/rtl/edf_if.sv
hw/rtl/edf_ctrl.sv
hw/rtl/edf_datapath.sv
hw/rtl/edf_ready_queue_scheduler.sv
sim/tb_edf_ready_queue_scheduler.sv
